>>> rtl/npcs_pkg.sv
// Package for the nearest palette color search unit.
// Sizes, command codes, the state type and chan_sq; no dependencies.
`default_nettype none

package npcs_pkg;

    localparam int PALETTE_DEPTH = 256;
    localparam int ADDR_W        = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    // Searchable entries are limited by the 8-bit index field.
    localparam int EFF_MAX       = (PALETTE_DEPTH < 256) ? PALETTE_DEPTH : 256;
    localparam int IDX_W         = (EFF_MAX > 1) ? $clog2(EFF_MAX) : 1;

    localparam int CNT_W         = 9;
    localparam int COLOR_W       = 24;
    localparam int CHAN_W        = 8;
    localparam int SQ_W          = 2 * CHAN_W;
    localparam int DIST_W        = 18;
    localparam int OUT_IDX_W     = 8;

    localparam logic [CNT_W-1:0] COUNT_RESET = 9'd147;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_QUERY = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    function automatic logic [SQ_W-1:0] chan_sq(input logic [CHAN_W-1:0] a,
                                               input logic [CHAN_W-1:0] b);
        logic [CHAN_W-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return d * d;
    endfunction

endpackage

`default_nettype wire

>>> rtl/nearest_palette_color_search_unit.sv
// Nearest palette color search: palette RAM, scan controller and distance pipe.
// Depends on npcs_pkg.
//
//  channel | direction | signals                                        | beat
//  in      | sink      | i_in_valid/o_in_ready, i_command,              | load or query
//          |           | i_entry_index, i_color_rgb                     |
//  out     | source    | o_out_valid/i_out_ready, o_nearest_index,      | one per query
//          |           | o_best_distance                                |
//  cfg     | sink      | i_cfg_valid/o_cfg_ready, i_cfg_palette_count   | count write
//
// A load writes an in-range palette entry and keeps the input ready. A query does
// one palette RAM read per entry through a single read port, then passes three
// pipe stages and the output register load. The result sits in an output
// register, so a new item is taken while it waits; a finished query holds in
// ST_DONE only if that register is still full. Synchronous active-low reset
// clears control state only; the palette RAM is not cleared.
`default_nettype none

module nearest_palette_color_search_unit
    import npcs_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic                  i_command,
    input  wire logic [7:0]            i_entry_index,
    input  wire logic [COLOR_W-1:0]    i_color_rgb,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [OUT_IDX_W-1:0]       o_nearest_index,
    output logic [DIST_W-1:0]          o_best_distance,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CNT_W-1:0]      i_cfg_palette_count
);

    logic [COLOR_W-1:0] r_palette [PALETTE_DEPTH];

    t_state r_state, n_state;

    logic [CNT_W-1:0]     r_count;
    logic [IDX_W-1:0]     r_last_addr, n_last_addr;
    logic [IDX_W-1:0]     r_rd_addr;
    logic [COLOR_W-1:0]   r_query;
    logic [COLOR_W-1:0]   r_rd_data;

    logic                 r_v1, r_last1;
    logic [IDX_W-1:0]     r_idx1;
    logic                 r_v2, r_last2;
    logic [IDX_W-1:0]     r_idx2;
    logic [SQ_W-1:0]      r_sq_r, r_sq_g, r_sq_b;

    logic [IDX_W-1:0]     r_best_idx;
    logic [DIST_W-1:0]    r_best_dist;
    logic [DIST_W-1:0]    dist_sum;

    logic                 r_out_valid;
    logic [OUT_IDX_W-1:0] r_out_index;
    logic [DIST_W-1:0]    r_out_dist;

    logic in_ready, rd_en, out_load;
    logic in_fire, load_fire, query_fire, load_in_range, out_free;

    assign in_fire       = i_in_valid && in_ready;
    assign load_fire     = in_fire && (i_command == CMD_LOAD);
    assign query_fire    = in_fire && (i_command == CMD_QUERY);
    assign load_in_range = 32'(i_entry_index) < PALETTE_DEPTH;
    assign out_free      = !r_out_valid || i_out_ready;

    // Count of zero searches entry 0; large counts saturate.
    always_comb begin
        if (r_count == '0) begin
            n_last_addr = '0;
        end else if (32'(r_count) > EFF_MAX) begin
            n_last_addr = IDX_W'(EFF_MAX - 1);
        end else begin
            n_last_addr = IDX_W'(r_count - 9'd1);
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (query_fire) n_state = ST_SCAN;
            ST_SCAN:  if (r_rd_addr == r_last_addr) n_state = ST_DRAIN;
            ST_DRAIN: if (r_v2 && r_last2) n_state = ST_DONE;
            ST_DONE:  if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        in_ready = 1'b0;
        rd_en    = 1'b0;
        out_load = 1'b0;
        unique case (r_state)
            ST_IDLE:  in_ready = 1'b1;
            ST_SCAN:  rd_en    = 1'b1;
            ST_DRAIN: ;
            ST_DONE:  out_load = out_free;
            default:  ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= COUNT_RESET;
        end else if (i_cfg_valid) begin
            r_count <= i_cfg_palette_count;
        end
    end

    // Palette RAM: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (load_fire && load_in_range) begin
            r_palette[ADDR_W'(i_entry_index)] <= i_color_rgb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_palette[ADDR_W'(r_rd_addr)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (query_fire) begin
            r_query     <= i_color_rgb;
            r_last_addr <= n_last_addr;
            r_rd_addr   <= '0;
        end else if (rd_en) begin
            r_rd_addr   <= r_rd_addr + IDX_W'(1);
        end
    end

    // Pipe valids.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= rd_en;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx1  <= r_rd_addr;
        r_last1 <= (r_rd_addr == r_last_addr);
        r_idx2  <= r_idx1;
        r_last2 <= r_last1;
        r_sq_r  <= chan_sq(r_rd_data[23:16], r_query[23:16]);
        r_sq_g  <= chan_sq(r_rd_data[15:8],  r_query[15:8]);
        r_sq_b  <= chan_sq(r_rd_data[7:0],   r_query[7:0]);
    end

    assign dist_sum = DIST_W'(r_sq_r) + DIST_W'(r_sq_g) + DIST_W'(r_sq_b);

    // Strict less-than keeps the lowest index on a tie.
    always_ff @(posedge i_clk) begin
        if (r_v2 && ((r_idx2 == '0) || (dist_sum < r_best_dist))) begin
            r_best_idx  <= r_idx2;
            r_best_dist <= dist_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_index <= OUT_IDX_W'(r_best_idx);
            r_out_dist  <= r_best_dist;
        end
    end

    assign o_in_ready      = in_ready;
    assign o_cfg_ready     = 1'b1;
    assign o_out_valid     = r_out_valid;
    assign o_nearest_index = r_out_index;
    assign o_best_distance = r_out_dist;

endmodule

`default_nettype wire

>>> rtl/npcs_checker.sv
// Port-level checks for the nearest palette color search unit, plus bind.
// Depends on npcs_pkg and nearest_palette_color_search_unit.
`default_nettype none

module npcs_checker
    import npcs_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_in_valid,
    input wire logic                 o_in_ready,
    input wire logic                 i_command,
    input wire logic                 o_out_valid,
    input wire logic                 i_out_ready,
    input wire logic [OUT_IDX_W-1:0] o_nearest_index,
    input wire logic [DIST_W-1:0]    o_best_distance
);

    localparam logic [DIST_W-1:0] DIST_MAX = 18'd195075;

    // Result beat holds until taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            $stable(o_nearest_index) && $stable(o_best_distance))
        else $error("result payload changed while stalled");

    // A query occupies the block; a load does not.
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_command == CMD_QUERY) |=> !o_in_ready)
        else $error("input taken during a scan");

    a_load_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_command == CMD_LOAD) |=> o_in_ready)
        else $error("load stalled the input");

    a_dist_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_best_distance <= DIST_MAX))
        else $error("distance out of range");

endmodule

bind nearest_palette_color_search_unit npcs_checker u_npcs_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .i_command       (i_command),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_nearest_index (o_nearest_index),
    .o_best_distance (o_best_distance)
);

`default_nettype wire
